// ----- hdl/brb_pkg.sv -----
// Shared types, codes and constants for the byte ring buffer FIFO.
package brb_pkg;

	localparam int DEPTH_DEF   = 1024;
	localparam int MAX_POP_DEF = 64;

	localparam int SIZE_W  = 11;
	localparam int LEN_W   = 11;
	localparam int DATA_W  = 8;
	localparam int HELD_W  = 10;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 24;

	// command queue between front and back; power of two
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_DISCARD = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_REFUSED  = 2'd1,
		STAT_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_POP,
		CMD_DISCARD
	} cmd_kind_t;

	typedef enum logic {
		BK_CMD,
		BK_POP
	} back_state_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic               first;  // first beat of a push run
		logic               wr;     // push beat carries a byte
		logic               ends;   // command produces a result beat
		logic [LEN_W-1:0]   len;
		logic [DATA_W-1:0]  data;
	} cmd_t;

	typedef struct packed {
		logic               is_read;
		logic               last;
		status_t            status;
		logic [HELD_W-1:0]  held;
	} res_meta_t;

endpackage

// ----- hdl/byte_ring_buffer_fifo.sv -----
// Top level of the byte ring buffer FIFO: front, command queue and back.
//
// Byte FIFO kept in a ring of size_in_use bytes (at most size_in_use - 1 held).
// Input stream s_axis: tuser is the operation (push byte, pop, discard), tdata
// carries length and data byte, tlast closes a push run. A push run is taken
// or refused whole on its first beat; one status beat comes on its last beat.
// A pop of N bytes returns N beats (tlast on the last) or one status beat.
// Output stream m_axis: tdata carries the byte read and the fill level after
// the operation, tuser the status, tlast the final beat of an operation.
// cfg_we/cfg_wdata set the ring size (clamped to 2..DEPTH) and empty the ring;
// write it only while the block is idle.
// Throughput: one push beat per cycle unless the queue or output stalls; a pop
// holds the back end while its bytes stream out, one byte per cycle while
// stage 1 frees, set by the single read port of the ring store. Results pass
// the command queue, then stage 1 (ring store read), then the output register.
// A 4-entry command queue between front and back lets input keep flowing
// while the output is stalled; once it fills, s_axis_tready drops. Results
// wait in the output register while m_axis_tready is low.
// Reset empties the ring and sets the size to 1024 (or DEPTH if smaller);
// no clearing pass is needed since the fill count guards the store.
module byte_ring_buffer_fifo #(
	parameter int DEPTH   = brb_pkg::DEPTH_DEF,
	parameter int MAX_POP = brb_pkg::MAX_POP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [brb_pkg::SIZE_W-1:0]       cfg_wdata,   // size_in_use
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [brb_pkg::TDATA_IN_W-1:0]   s_axis_tdata, // length[10:0], data_byte[18:11]
	input  logic [brb_pkg::OP_W-1:0]         s_axis_tuser, // operation[1:0]
	input  logic                             s_axis_tlast, // run_last
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [brb_pkg::TDATA_OUT_W-1:0]  m_axis_tdata, // read_byte[7:0], bytes_held[17:8]
	output logic [brb_pkg::STAT_W-1:0]       m_axis_tuser, // status[1:0]
	output logic                             m_axis_tlast  // last_of_run
);

	brb_pkg::cmd_t fe_cmd;
	brb_pkg::cmd_t q_cmd;
	logic          fe_valid;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;

	// classify beats and follow push runs
	brb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.cmd_valid     (fe_valid),
		.cmd           (fe_cmd)
	);

	brb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_valid),
		.push_cmd (fe_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	// ring store, fill accounting and result stream
	brb_back #(
		.DEPTH   (DEPTH),
		.MAX_POP (MAX_POP)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- hdl/brb_front.sv -----
// Input side: accepts beats, tracks push runs and turns beats into commands.
module brb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [brb_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
	input  logic [brb_pkg::OP_W-1:0]        s_axis_tuser,
	input  logic                            s_axis_tlast,
	input  logic                            q_full,
	output logic                            cmd_valid,
	output brb_pkg::cmd_t                   cmd
);

	logic [brb_pkg::LEN_W-1:0] left_q;
	logic [brb_pkg::LEN_W-1:0] left_nxt;
	logic [brb_pkg::LEN_W-1:0] len;
	logic [brb_pkg::LEN_W-1:0] cur;
	logic [brb_pkg::LEN_W-1:0] rem;
	logic                      accept;

	assign len           = s_axis_tdata[brb_pkg::LEN_W-1:0];
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		left_nxt  = left_q;
		cmd_valid = 1'b0;
		cmd       = '0;
		cmd.kind  = brb_pkg::CMD_PUSH;
		cmd.len   = len;
		cmd.data  = s_axis_tdata[brb_pkg::LEN_W +: brb_pkg::DATA_W];
		cur       = (left_q == '0) ? len : left_q;
		rem       = cur - brb_pkg::LEN_W'(1);
		if (accept) begin
			case (s_axis_tuser)
				brb_pkg::OP_PUSH: begin
					cmd_valid = 1'b1;
					cmd.first = (left_q == '0);
					if (left_q == '0 && len == '0) begin
						// zero-length run: status only
						cmd.ends = 1'b1;
					end else begin
						cmd.wr   = 1'b1;
						cmd.ends = (rem == '0) || s_axis_tlast;
						left_nxt = cmd.ends ? '0 : rem;
					end
				end
				brb_pkg::OP_POP: begin
					cmd_valid = 1'b1;
					cmd.kind  = brb_pkg::CMD_POP;
					cmd.ends  = 1'b1;
					left_nxt  = '0;
				end
				brb_pkg::OP_DISCARD: begin
					cmd_valid = 1'b1;
					cmd.kind  = brb_pkg::CMD_DISCARD;
					cmd.ends  = 1'b1;
					left_nxt  = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (cfg_we) begin
			left_q <= '0;
		end else begin
			left_q <= left_nxt;
		end
	end

endmodule

// ----- hdl/brb_queue.sv -----
// Short command queue decoupling the front from the back.
module brb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brb_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output brb_pkg::cmd_t q_cmd
);

	localparam int QA = $clog2(brb_pkg::QUEUE_DEPTH);

	brb_pkg::cmd_t entries_q [brb_pkg::QUEUE_DEPTH];
	logic [QA-1:0] wr_ptr_q;
	logic [QA-1:0] rd_ptr_q;
	logic [QA:0]   count_q;

	assign full    = (count_q == (QA+1)'(brb_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QA+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QA+1)'(1);
			end
		end
	end

endmodule

// ----- hdl/brb_back.sv -----
// Execution side: ring store, indices, pop sequencer and output stages.
module brb_back #(
	parameter int DEPTH   = brb_pkg::DEPTH_DEF,
	parameter int MAX_POP = brb_pkg::MAX_POP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [brb_pkg::SIZE_W-1:0]       cfg_wdata,
	input  logic                             q_valid,
	input  brb_pkg::cmd_t                    q_cmd,
	output logic                             q_pop,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [brb_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
	output logic [brb_pkg::STAT_W-1:0]       m_axis_tuser,
	output logic                             m_axis_tlast
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CW    = ((IDX_W > brb_pkg::SIZE_W) ? IDX_W : brb_pkg::SIZE_W) + 1;
	localparam int CNT_W = $clog2(MAX_POP + 1);
	localparam int SIZE_RESET = (DEPTH < 1024) ? DEPTH : 1024;
	localparam int PAD_W = brb_pkg::TDATA_OUT_W - brb_pkg::HELD_W - brb_pkg::DATA_W;

	logic [brb_pkg::DATA_W-1:0] mem [DEPTH];

	brb_pkg::back_state_t       state_q, state_nxt;
	logic [IDX_W-1:0]           ridx_q, ridx_nxt;
	logic [IDX_W-1:0]           widx_q, widx_nxt;
	logic [IDX_W-1:0]           rd_ptr_q, rd_ptr_nxt;
	logic [CNT_W-1:0]           cnt_q, cnt_nxt;
	logic [brb_pkg::SIZE_W-1:0] fill_q, fill_nxt;
	logic [brb_pkg::SIZE_W-1:0] size_q, size_new;
	logic                       acc_q, acc_nxt, acc_cur;

	logic                       valid_s1;
	brb_pkg::res_meta_t         meta_s1;
	logic [brb_pkg::DATA_W-1:0] rd_data_s1;
	logic                       valid_s2;
	logic [brb_pkg::DATA_W-1:0] byte_s2;
	logic                       last_s2;
	brb_pkg::status_t           status_s2;
	logic [brb_pkg::HELD_W-1:0] held_s2;

	logic                       s2_load, s1_free;
	logic                       issue, mem_we, mem_re;
	brb_pkg::res_meta_t         issue_meta;

	logic [CW-1:0]              widx_inc, rdp_inc, ridx_add, room_need;
	logic [IDX_W-1:0]           widx_wrap, rdp_wrap, ridx_adv;
	logic                       fits, len_gt_fill, len_gt_max;
	logic [brb_pkg::SIZE_W-1:0] fill_less;

	assign s2_load = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s1_free = !valid_s1 || s2_load;

	// index arithmetic; a sum that is wrapped stays below twice the ring size
	assign widx_inc  = CW'(widx_q) + CW'(1);
	assign widx_wrap = (widx_inc == CW'(size_q)) ? '0 : IDX_W'(widx_inc);
	assign rdp_inc   = CW'(rd_ptr_q) + CW'(1);
	assign rdp_wrap  = (rdp_inc == CW'(size_q)) ? '0 : IDX_W'(rdp_inc);
	assign ridx_add  = CW'(ridx_q) + CW'(q_cmd.len);
	assign ridx_adv  = (ridx_add >= CW'(size_q)) ? IDX_W'(ridx_add - CW'(size_q))
	                                             : IDX_W'(ridx_add);
	assign room_need   = CW'(q_cmd.len) + CW'(fill_q) + CW'(1);
	assign fits        = (room_need <= CW'(size_q));
	assign len_gt_fill = (q_cmd.len > fill_q);
	assign len_gt_max  = (CW'(q_cmd.len) > CW'(MAX_POP));
	assign fill_less   = fill_q - q_cmd.len;

	always_comb begin
		if (cfg_wdata < brb_pkg::SIZE_W'(2)) begin
			size_new = brb_pkg::SIZE_W'(2);
		end else if (CW'(cfg_wdata) > CW'(DEPTH)) begin
			size_new = brb_pkg::SIZE_W'(DEPTH);
		end else begin
			size_new = cfg_wdata;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		ridx_nxt   = ridx_q;
		widx_nxt   = widx_q;
		rd_ptr_nxt = rd_ptr_q;
		cnt_nxt    = cnt_q;
		fill_nxt   = fill_q;
		acc_nxt    = acc_q;
		acc_cur    = q_cmd.first ? fits : acc_q;
		q_pop      = 1'b0;
		issue      = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		issue_meta = '0;
		issue_meta.last   = 1'b1;
		issue_meta.status = brb_pkg::STAT_OK;
		issue_meta.held   = brb_pkg::HELD_W'(fill_q);
		case (state_q)
			brb_pkg::BK_CMD: begin
				if (q_valid && (!q_cmd.ends || s1_free)) begin
					q_pop = 1'b1;
					case (q_cmd.kind)
						brb_pkg::CMD_PUSH: begin
							acc_nxt = acc_cur;
							if (acc_cur && q_cmd.wr) begin
								mem_we   = 1'b1;
								widx_nxt = widx_wrap;
								fill_nxt = fill_q + brb_pkg::SIZE_W'(1);
							end
							issue             = q_cmd.ends;
							issue_meta.status = acc_cur ? brb_pkg::STAT_OK
							                            : brb_pkg::STAT_REFUSED;
							issue_meta.held   = brb_pkg::HELD_W'(fill_nxt);
						end
						brb_pkg::CMD_DISCARD: begin
							issue = 1'b1;
							if (len_gt_fill) begin
								issue_meta.status = brb_pkg::STAT_REFUSED;
							end else begin
								ridx_nxt        = ridx_adv;
								fill_nxt        = fill_less;
								issue_meta.held = brb_pkg::HELD_W'(fill_less);
							end
						end
						brb_pkg::CMD_POP: begin
							if (len_gt_max) begin
								issue             = 1'b1;
								issue_meta.status = brb_pkg::STAT_TOO_LONG;
							end else if (len_gt_fill) begin
								issue             = 1'b1;
								issue_meta.status = brb_pkg::STAT_REFUSED;
							end else if (q_cmd.len == '0) begin
								issue = 1'b1;
							end else begin
								// indices move now; bytes stream out from rd_ptr
								rd_ptr_nxt = ridx_q;
								cnt_nxt    = CNT_W'(q_cmd.len);
								ridx_nxt   = ridx_adv;
								fill_nxt   = fill_less;
								state_nxt  = brb_pkg::BK_POP;
							end
						end
						default: ;
					endcase
				end
			end
			brb_pkg::BK_POP: begin
				if (s1_free) begin
					issue              = 1'b1;
					mem_re             = 1'b1;
					issue_meta.is_read = 1'b1;
					issue_meta.last    = (cnt_q == CNT_W'(1));
					rd_ptr_nxt         = rdp_wrap;
					cnt_nxt            = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_nxt = brb_pkg::BK_CMD;
					end
				end
			end
			default: state_nxt = brb_pkg::BK_CMD;
		endcase
	end

	// ring store, read data registered into stage 1
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[widx_q] <= q_cmd.data;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= brb_pkg::BK_CMD;
			ridx_q   <= '0;
			widx_q   <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			fill_q   <= '0;
			acc_q    <= 1'b0;
			size_q   <= brb_pkg::SIZE_W'(SIZE_RESET);
		end else if (cfg_we) begin
			state_q  <= brb_pkg::BK_CMD;
			ridx_q   <= '0;
			widx_q   <= '0;
			fill_q   <= '0;
			acc_q    <= 1'b0;
			size_q   <= size_new;
		end else begin
			state_q  <= state_nxt;
			ridx_q   <= ridx_nxt;
			widx_q   <= widx_nxt;
			rd_ptr_q <= rd_ptr_nxt;
			cnt_q    <= cnt_nxt;
			fill_q   <= fill_nxt;
			acc_q    <= acc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1 <= issue_meta;
		end
		if (s2_load) begin
			byte_s2   <= meta_s1.is_read ? rd_data_s1 : '0;
			last_s2   <= meta_s1.last;
			status_s2 <= meta_s1.status;
			held_s2   <= meta_s1.held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s2_load) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, held_s2, byte_s2};
	assign m_axis_tuser  = status_s2;
	assign m_axis_tlast  = last_s2;

endmodule

// ----- hdl/brb_checker.sv -----
// Port-level checks for the byte ring buffer FIFO, bound to the top level.
module brb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [brb_pkg::SIZE_W-1:0]       cfg_wdata,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [brb_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
	input logic [brb_pkg::OP_W-1:0]         s_axis_tuser,
	input logic                             s_axis_tlast,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [brb_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
	input logic [brb_pkg::STAT_W-1:0]       m_axis_tuser,
	input logic                             m_axis_tlast
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast)))
		else $error("result beat changed while stalled");

	// a failure status is always a single closing beat with no byte
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != brb_pkg::STAT_OK))
			|-> (m_axis_tlast && (m_axis_tdata[brb_pkg::DATA_W-1:0] == '0)))
		else $error("failure status on a data beat");

	// only pop bursts have non-closing beats, and those are successful
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == brb_pkg::STAT_OK))
		else $error("non-closing beat with failure status");

	// within a pop burst the reported fill level does not change
	a_burst_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast)
			##1 m_axis_tvalid |-> $stable(m_axis_tdata[brb_pkg::DATA_W +: brb_pkg::HELD_W])
			|| $past(cfg_we))
		else $error("fill level changed inside a pop burst");

endmodule

bind byte_ring_buffer_fifo brb_checker u_brb_checker (.*);
